// ===== src/tem_pkg.sv =====
// ----------------------------------------------------------------------------
// Tracker event to MIDI package
// Shared types, codes and defaults for the tracker event to MIDI translator.
// ----------------------------------------------------------------------------
`default_nettype none

package tem_pkg;

    // Parameter defaults.
    localparam int TRACK_COUNT_DEF   = 64;
    localparam int CHANNEL_COUNT_DEF = 16;

    // Note codes.
    localparam logic [7:0] NOTE_OFF_CODE = 8'd120;
    localparam logic [7:0] NOTE_RAW_CODE = 8'd123;

    // Effect command codes.
    localparam logic [7:0] CMD_PATCH = 8'hC1;
    localparam logic [7:0] CMD_CHAN  = 8'hC2;
    localparam logic [7:0] CMD_VOL_A = 8'hCC;
    localparam logic [7:0] CMD_VOL_B = 8'h0C;

    localparam logic [7:0] INS_NONE = 8'd255;

    // MIDI message types (status high nibble).
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_CTRL     = 4'hB;
    localparam logic [3:0] STATUS_PATCH    = 4'hC;

    localparam logic [6:0] CTRL_ALL_NOTES_OFF = 7'h7B;

    localparam logic [6:0] VELOCITY_RESET = 7'd100;

    typedef struct packed {
        logic       action;
        logic [5:0] track;
        logic [7:0] note_code;
        logic [7:0] instrument;
        logic [7:0] command;
        logic [7:0] argument;
    } evt_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic       last_of_run;
    } msg_word_t;

    // One three-byte message before it is tagged with its position in a run.
    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
    } msg_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ON,
        KIND_OFF,
        KIND_RAW,
        KIND_STOP
    } kind_t;

    // Classified event as it travels from the front end to the back end.
    typedef struct packed {
        kind_t      kind;
        logic       set_chan;
        logic [3:0] chan_val;
        logic       patch;
        logic [6:0] patch_prog;
        logic       remap;
        logic [3:0] remap_val;
        logic [6:0] note;
        logic [6:0] vel;
        msg_t       raw;
    } rec_t;

endpackage

`default_nettype wire

// ===== src/tem_front.sv =====
// ----------------------------------------------------------------------------
// Tracker event front end
// Accepts events, drops out-of-range tracks and classifies the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_front #(
    parameter int TRACK_COUNT = tem_pkg::TRACK_COUNT_DEF,
    localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1
) (
    input  logic              evt_valid,
    output logic              evt_ready,
    input  tem_pkg::evt_t     evt,
    input  logic [6:0]        default_velocity,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [TW-1:0]     push_idx,
    output tem_pkg::rec_t     push_rec
);

    logic          in_range;
    logic [TW+5:0] track_ext;

    assign in_range  = (32'(evt.track) < TRACK_COUNT);
    assign track_ext = (TW + 6)'(evt.track);
    assign push_idx  = track_ext[TW-1:0];

    // Items for tracks that do not exist are taken and dropped here.
    assign evt_ready  = push_ready;
    assign push_valid = evt_valid && (evt.action || in_range);

    always_comb
    begin
        push_rec = '0;
        if (evt.action) begin
            push_rec.kind = tem_pkg::KIND_STOP;
        end else if (evt.note_code < tem_pkg::NOTE_OFF_CODE) begin
            push_rec.kind = tem_pkg::KIND_ON;
        end else if (evt.note_code == tem_pkg::NOTE_OFF_CODE) begin
            push_rec.kind = tem_pkg::KIND_OFF;
        end else if (evt.note_code == tem_pkg::NOTE_RAW_CODE) begin
            push_rec.kind = tem_pkg::KIND_RAW;
        end else begin
            push_rec.kind = tem_pkg::KIND_NONE;
        end

        push_rec.set_chan   = (evt.command == tem_pkg::CMD_CHAN);
        push_rec.chan_val   = evt.argument[3:0];
        push_rec.patch      = (evt.command == tem_pkg::CMD_PATCH);
        push_rec.patch_prog = evt.argument[6:0];
        push_rec.remap      = (evt.instrument != tem_pkg::INS_NONE);
        push_rec.remap_val  = evt.instrument[3:0];
        push_rec.note       = evt.note_code[6:0];

        if (evt.command == tem_pkg::CMD_VOL_A || evt.command == tem_pkg::CMD_VOL_B) begin
            push_rec.vel = evt.argument[7:1];
        end else begin
            push_rec.vel = default_velocity;
        end

        // A raw message needs no track state, so it is built completely here.
        if (evt.instrument[7:4] == tem_pkg::STATUS_PATCH) begin
            push_rec.raw.status = {tem_pkg::STATUS_PATCH, evt.instrument[3:0]};
            push_rec.raw.data1  = evt.command[6:0];
            push_rec.raw.data2  = 7'd0;
        end else begin
            push_rec.raw.status = evt.instrument;
            push_rec.raw.data1  = evt.command[6:0];
            push_rec.raw.data2  = evt.argument[6:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/tem_queue.sv =====
// ----------------------------------------------------------------------------
// Tracker event queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam logic [1:0] ENTRIES = 2'd2;

    logic [WIDTH-1:0] store_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != ENTRIES);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/tem_back.sv =====
// ----------------------------------------------------------------------------
// Tracker event back end
// Looks up track state, updates it and sends the resulting MIDI words.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_back #(
    parameter int TRACK_COUNT   = tem_pkg::TRACK_COUNT_DEF,
    parameter int CHANNEL_COUNT = tem_pkg::CHANNEL_COUNT_DEF,
    localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic [TW-1:0]      q_idx,
    input  tem_pkg::rec_t      q_rec,
    output logic               msg_valid,
    input  logic               msg_ready,
    output tem_pkg::msg_word_t msg
);

    localparam int CW = $clog2(CHANNEL_COUNT);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic [6:0] note;
        logic [3:0] chan;
    } entry_t;

    state_t             state_reg;
    state_t             state_next;
    tem_pkg::rec_t      rec_reg;
    logic [TW-1:0]      idx_reg;
    entry_t             rd_reg;
    entry_t             track_mem [TRACK_COUNT];
    logic [TRACK_COUNT-1:0] note_valid_reg;
    logic [TRACK_COUNT-1:0] chan_valid_reg;

    tem_pkg::msg_t      list_reg [3];
    logic [1:0]         list_cnt_reg;
    logic [1:0]         list_idx_reg;
    logic               stop_reg;
    logic [CW-1:0]      chan_cnt_reg;

    logic               out_valid_reg;
    tem_pkg::msg_word_t out_word_reg;

    tem_pkg::msg_t      calc_list [3];
    logic [1:0]         calc_cnt;
    logic [3:0]         ch_cur;
    logic [3:0]         ch_a;
    logic [3:0]         ch_b;
    logic               nv;
    logic               note_set;
    logic               note_clear;
    logic               mem_we;
    entry_t             wr_entry;

    tem_pkg::msg_t      cur_msg;
    logic               cur_last;
    logic               load_ok;
    logic               load;
    logic               pop;

    // ------------------------------------------------------------------
    // Current message of the run and handshake toward the output stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (stop_reg) begin
            cur_msg.status = {tem_pkg::STATUS_CTRL, 4'(chan_cnt_reg)};
            cur_msg.data1  = tem_pkg::CTRL_ALL_NOTES_OFF;
            cur_msg.data2  = 7'd0;
            cur_last       = (chan_cnt_reg == CW'(CHANNEL_COUNT - 1));
        end else begin
            cur_msg  = list_reg[list_idx_reg];
            cur_last = (list_idx_reg == (list_cnt_reg - 2'd1));
        end
    end

    assign load_ok = !out_valid_reg || msg_ready;
    assign load    = (state_reg == S_EMIT) && load_ok;
    assign pop     = q_valid && ((state_reg == S_IDLE) || (load && cur_last));
    assign q_ready = pop;

    // ------------------------------------------------------------------
    // State lookup result: messages and write-back for the current event.
    // ------------------------------------------------------------------
    always_comb
    begin
        calc_list  = '{default: '0};
        calc_cnt   = 2'd0;
        note_set   = 1'b0;
        note_clear = 1'b0;
        nv         = note_valid_reg[idx_reg];
        ch_cur     = chan_valid_reg[idx_reg] ? rd_reg.chan : 4'd0;
        ch_a       = rec_reg.set_chan ? rec_reg.chan_val : ch_cur;
        ch_b       = ch_a;

        if (rec_reg.patch) begin
            calc_list[calc_cnt].status = {tem_pkg::STATUS_PATCH, ch_a};
            calc_list[calc_cnt].data1  = rec_reg.patch_prog;
            calc_list[calc_cnt].data2  = 7'd0;
            calc_cnt                   = calc_cnt + 2'd1;
        end

        unique case (rec_reg.kind)
            tem_pkg::KIND_ON:
            begin
                if (rec_reg.remap) begin
                    ch_b = rec_reg.remap_val;
                end
                if (nv) begin
                    calc_list[calc_cnt].status = {tem_pkg::STATUS_NOTE_OFF, ch_b};
                    calc_list[calc_cnt].data1  = rd_reg.note;
                    calc_list[calc_cnt].data2  = 7'd0;
                    calc_cnt                   = calc_cnt + 2'd1;
                end
                calc_list[calc_cnt].status = {tem_pkg::STATUS_NOTE_ON, ch_b};
                calc_list[calc_cnt].data1  = rec_reg.note;
                calc_list[calc_cnt].data2  = rec_reg.vel;
                calc_cnt                   = calc_cnt + 2'd1;
                note_set                   = 1'b1;
            end
            tem_pkg::KIND_OFF:
            begin
                // Without a sounding note the instrument does not remap.
                if (nv) begin
                    if (rec_reg.remap) begin
                        ch_b = rec_reg.remap_val;
                    end
                    calc_list[calc_cnt].status = {tem_pkg::STATUS_NOTE_OFF, ch_b};
                    calc_list[calc_cnt].data1  = rd_reg.note;
                    calc_list[calc_cnt].data2  = 7'd0;
                    calc_cnt                   = calc_cnt + 2'd1;
                    note_clear                 = 1'b1;
                end
            end
            tem_pkg::KIND_RAW:
            begin
                calc_list[calc_cnt] = rec_reg.raw;
                calc_cnt            = calc_cnt + 2'd1;
            end
            tem_pkg::KIND_NONE, tem_pkg::KIND_STOP:
            begin
            end
            default:
            begin
            end
        endcase

        mem_we        = (state_reg == S_CALC) && (rec_reg.kind != tem_pkg::KIND_STOP);
        wr_entry.chan = ch_b;
        wr_entry.note = note_set ? rec_reg.note : rd_reg.note;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop) begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (rec_reg.kind == tem_pkg::KIND_STOP || calc_cnt != 2'd0) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (load && cur_last) begin
                    state_next = pop ? S_CALC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            note_valid_reg <= '0;
            chan_valid_reg <= '0;
            stop_reg       <= 1'b0;
            list_cnt_reg   <= 2'd0;
            list_idx_reg   <= 2'd0;
            chan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (mem_we) begin
                chan_valid_reg[idx_reg] <= 1'b1;
                if (note_set) begin
                    note_valid_reg[idx_reg] <= 1'b1;
                end else if (note_clear) begin
                    note_valid_reg[idx_reg] <= 1'b0;
                end
            end

            if (state_reg == S_CALC) begin
                stop_reg     <= (rec_reg.kind == tem_pkg::KIND_STOP);
                list_cnt_reg <= calc_cnt;
                list_idx_reg <= 2'd0;
                chan_cnt_reg <= '0;
            end else if (load) begin
                list_idx_reg <= list_idx_reg + 2'd1;
                chan_cnt_reg <= chan_cnt_reg + CW'(1);
            end

            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (msg_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the track state memory.
    always_ff @(posedge clk)
    begin
        if (pop) begin
            rec_reg <= q_rec;
            idx_reg <= q_idx;
            rd_reg  <= track_mem[q_idx];
        end
        if (mem_we) begin
            track_mem[idx_reg] <= wr_entry;
        end
        if (state_reg == S_CALC) begin
            list_reg <= calc_list;
        end
        if (load) begin
            out_word_reg.status_byte <= cur_msg.status;
            out_word_reg.first_data  <= cur_msg.data1;
            out_word_reg.second_data <= cur_msg.data2;
            out_word_reg.last_of_run <= cur_last;
        end
    end

    assign msg_valid = out_valid_reg;
    assign msg       = out_word_reg;

endmodule

`default_nettype wire

// ===== src/tracker_event_to_midi.sv =====
// ----------------------------------------------------------------------------
// Tracker event to MIDI translator
// Turns tracker pattern events into three-byte MIDI short messages.
// ----------------------------------------------------------------------------
// Flow: an accepted event word passes through the queue, the lookup registers
// and the message list before its first word is loaded into the output register.
// Each event takes a lookup step and then sends its message words one at a time
// (one to three, one per channel for a stop); an event may also send nothing.
// Reset: all tracks have no sounding note and map to channel 0; the default
// velocity returns to 100. No clearing pass is needed; the block is ready at once.
`default_nettype none

module tracker_event_to_midi #(
    parameter int TRACK_COUNT   = tem_pkg::TRACK_COUNT_DEF,
    parameter int CHANNEL_COUNT = tem_pkg::CHANNEL_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data,
    input  logic               evt_valid,
    output logic               evt_ready,
    input  tem_pkg::evt_t      evt,
    output logic               msg_valid,
    input  logic               msg_ready,
    output tem_pkg::msg_word_t msg
);

    localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int RW = $bits(tem_pkg::rec_t);
    localparam int QW = TW + RW;

    // The default velocity register. Writes must arrive only while the block is
    // idle; the user is bound to this, the block itself does not enforce it.
    logic [6:0]     default_velocity_reg;

    logic           push_valid;
    logic           push_ready;
    logic [TW-1:0]  push_idx;
    tem_pkg::rec_t  push_rec;

    logic           q_valid;
    logic           q_ready;
    logic [QW-1:0]  q_data;
    tem_pkg::rec_t  q_rec;
    logic [TW-1:0]  q_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            default_velocity_reg <= tem_pkg::VELOCITY_RESET;
        end else if (cfg_valid) begin
            default_velocity_reg <= cfg_data;
        end
    end

    // The front end classifies each incoming word: stop, note on, note off,
    // raw message or effects only. It works out everything that needs no
    // track state, such as the velocity and the raw message bytes.
    tem_front #(
        .TRACK_COUNT (TRACK_COUNT)
    ) u_front (
        .evt_valid        (evt_valid),
        .evt_ready        (evt_ready),
        .evt              (evt),
        .default_velocity (default_velocity_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_idx         (push_idx),
        .push_rec         (push_rec)
    );

    // A short queue lets the front end keep taking words while the back end
    // is still sending the messages of earlier events.
    tem_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_idx, push_rec}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_rec = q_data[RW-1:0];
    assign q_idx = q_data[QW-1:RW];

    // The back end reads the track's note and channel, builds up to three
    // messages (or an All Notes Off word per channel for a stop), writes the
    // track state back and feeds an output register one word per cycle unless
    // stalled. Events go in order, so a read never overtakes an earlier write.
    tem_back #(
        .TRACK_COUNT   (TRACK_COUNT),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_idx     (q_idx),
        .q_rec     (q_rec),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg)
    );

endmodule

`default_nettype wire

// ===== src/tem_checker.sv =====
// ----------------------------------------------------------------------------
// Tracker event to MIDI checker
// Port-level assertions on the message output of the translator.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               msg_valid,
    input logic               msg_ready,
    input tem_pkg::msg_word_t msg
);

    // A word that is not taken stays offered.
    a_msg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid)
        else $error("message word withdrawn before it was taken");

    a_msg_stable: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> $stable(msg))
        else $error("message word changed while stalled");

    // Only patch changes, note offs and All Notes Off words can be followed
    // by more words of the same run.
    a_non_last_type: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && !msg.last_of_run |->
            (msg.status_byte[7:4] == tem_pkg::STATUS_NOTE_OFF ||
             msg.status_byte[7:4] == tem_pkg::STATUS_PATCH ||
             msg.status_byte[7:4] == tem_pkg::STATUS_CTRL))
        else $error("unexpected message type inside a run");

    // A controller word inside a run belongs to a stop sequence.
    a_stop_run: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && !msg.last_of_run &&
            msg.status_byte[7:4] == tem_pkg::STATUS_CTRL |->
            msg.first_data == tem_pkg::CTRL_ALL_NOTES_OFF && msg.second_data == 7'd0)
        else $error("malformed All Notes Off word");

endmodule

bind tracker_event_to_midi tem_checker u_tem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg)
);

`default_nettype wire
